/* sv/i2clm_pkg.sv */
// Shared types and constants of the light sensor I2C master.
`timescale 1ns / 1ps

package i2clm_pkg;

	localparam int unsigned AddrW   = 7;
	localparam int unsigned TicksW  = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned RawW    = 16;
	localparam int unsigned LuxW    = 19;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS    = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD_TICKS = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ACK_POLL_LIMIT    = 2'd2;

	// Request codes.
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [AddrW-1:0]  RST_DEVICE_ADDRESS    = 7'd35;
	localparam logic [TicksW-1:0] RST_HALF_PERIOD_TICKS = 16'd4;
	localparam logic [TicksW-1:0] RST_ACK_POLL_LIMIT    = 16'd3000;

	typedef struct packed {
		logic [AddrW-1:0]  device_address;
		logic [TicksW-1:0] half_period_ticks;
		logic [TicksW-1:0] ack_poll_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] cmd_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic            scl_out;
		logic            sda_out;
		logic            busy_res;
		logic            done_res;
		logic            ack_error;
		logic [RawW-1:0] raw_light;
	} step_t;

endpackage

/* sv/i2clm_if.sv */
// Handshake channel interfaces of the light sensor I2C master.
`timescale 1ns / 1ps

interface i2clm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] cmd_byte;
	logic       sda_in;

	modport source (output valid, req_type, cmd_byte, sda_in, input ready);
	modport sink   (input valid, req_type, cmd_byte, sda_in, output ready);
endinterface

interface i2clm_res_if;
	logic        valid;
	logic        ready;
	logic        scl_out;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic        ack_error;
	logic [15:0] raw_light;
	logic [18:0] lux_x16;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, ack_error,
		raw_light, lux_x16, input ready);
	modport sink   (input valid, scl_out, sda_out, busy_res, done_res, ack_error,
		raw_light, lux_x16, output ready);
endinterface

interface i2clm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* sv/i2clm_seq.sv */
// Bus sequencer: holds the transaction state and advances it by one tick.
`timescale 1ns / 1ps

module i2clm_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  i2clm_pkg::item_t  item,
	input  i2clm_pkg::cfg_t   cfg,
	output i2clm_pkg::step_t  result
);

	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_ST_A     = 5'd1;
	localparam logic [4:0] PH_ST_B     = 5'd2;
	localparam logic [4:0] PH_ST_C     = 5'd3;
	localparam logic [4:0] PH_TX_LO    = 5'd4;
	localparam logic [4:0] PH_TX_HI    = 5'd5;
	localparam logic [4:0] PH_TX_TAIL  = 5'd6;
	localparam logic [4:0] PH_ACK_REL  = 5'd7;
	localparam logic [4:0] PH_ACK_HI   = 5'd8;
	localparam logic [4:0] PH_ACK_POLL = 5'd9;
	localparam logic [4:0] PH_ACK_LO   = 5'd10;
	localparam logic [4:0] PH_RX_HI    = 5'd11;
	localparam logic [4:0] PH_RX_LO    = 5'd12;
	localparam logic [4:0] PH_MA_A     = 5'd13;
	localparam logic [4:0] PH_MA_B     = 5'd14;
	localparam logic [4:0] PH_MA_C     = 5'd15;
	localparam logic [4:0] PH_NA_A     = 5'd16;
	localparam logic [4:0] PH_NA_B     = 5'd17;
	localparam logic [4:0] PH_NA_C     = 5'd18;
	localparam logic [4:0] PH_SP_A     = 5'd19;
	localparam logic [4:0] PH_SP_B     = 5'd20;

	localparam logic [1:0] STAGE_ADDR   = 2'd0;
	localparam logic [1:0] STAGE_FIRST  = 2'd1;
	localparam logic [1:0] STAGE_SECOND = 2'd2;

	logic [4:0]  phase_q, phase_d;
	logic [2:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] wait_q, wait_d;
	logic [15:0] poll_q, poll_d;
	logic [7:0]  cmd_q, cmd_d;
	logic        reading_q, reading_d;
	logic [7:0]  first_q, first_d;
	logic [15:0] meas_q, meas_d;
	logic        err_q, err_d;
	logic [1:0]  stage_q, stage_d;

	logic        start;
	logic [4:0]  phase_e;
	logic [15:0] half_ticks, poll_lim, wait_inc, poll_inc;
	logic        over, scl, sda, done;

	always_comb begin
		start      = (phase_q == PH_IDLE) &&
			(item.req_type == i2clm_pkg::REQ_WRITE || item.req_type == i2clm_pkg::REQ_READ);
		half_ticks = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
		poll_lim   = (cfg.ack_poll_limit == '0) ? 16'd1 : cfg.ack_poll_limit;

		phase_e   = start ? PH_ST_A : phase_q;
		reading_d = start ? (item.req_type == i2clm_pkg::REQ_READ) : reading_q;
		cmd_d     = (start && item.req_type == i2clm_pkg::REQ_WRITE) ? item.cmd_byte : cmd_q;
		err_d     = start ? 1'b0 : err_q;
		stage_d   = start ? STAGE_ADDR : stage_q;
		poll_d    = start ? 16'd0 : poll_q;
		wait_d    = start ? 16'd0 : wait_q;

		// Delay counter shared by every timed phase.
		wait_inc = wait_d + 16'd1;
		over     = (wait_inc >= half_ticks) || (wait_inc == 16'd0);
		poll_inc = poll_d + 16'd1;

		phase_d = phase_e;
		bit_d   = bit_q;
		shift_d = shift_q;
		first_d = first_q;
		meas_d  = meas_q;
		done    = 1'b0;

		case (phase_e)
			PH_ST_B:    begin scl = 1'b1; sda = 1'b0;       end
			PH_ST_C:    begin scl = 1'b0; sda = 1'b0;       end
			PH_TX_LO:   begin scl = 1'b0; sda = shift_q[7]; end
			PH_TX_HI:   begin scl = 1'b1; sda = shift_q[7]; end
			PH_TX_TAIL: begin scl = 1'b0; sda = shift_q[7]; end
			PH_ACK_REL: begin scl = 1'b0; sda = 1'b1;       end
			PH_ACK_LO:  begin scl = 1'b0; sda = 1'b1;       end
			PH_RX_LO:   begin scl = 1'b0; sda = 1'b1;       end
			PH_MA_A:    begin scl = 1'b0; sda = 1'b0;       end
			PH_MA_B:    begin scl = 1'b1; sda = 1'b0;       end
			PH_MA_C:    begin scl = 1'b0; sda = 1'b0;       end
			PH_NA_A:    begin scl = 1'b0; sda = 1'b1;       end
			PH_NA_C:    begin scl = 1'b0; sda = 1'b1;       end
			PH_SP_A:    begin scl = 1'b1; sda = 1'b0;       end
			default:    begin scl = 1'b1; sda = 1'b1;       end
		endcase

		if (phase_e inside {[PH_ST_A:PH_ACK_HI], [PH_ACK_LO:PH_SP_B]}) begin
			wait_d = over ? 16'd0 : wait_inc;
		end

		case (phase_e)
			PH_IDLE: ;
			PH_ST_A: if (over) phase_d = PH_ST_B;
			PH_ST_B: if (over) phase_d = PH_ST_C;
			PH_ST_C: if (over) begin
				shift_d = {cfg.device_address, reading_d};
				bit_d   = 3'd0;
				phase_d = PH_TX_LO;
			end
			PH_TX_LO: if (over) phase_d = PH_TX_HI;
			PH_TX_HI: if (over) begin
				if (bit_q == 3'd7) begin
					phase_d = PH_TX_TAIL;
				end else begin
					shift_d = {shift_q[6:0], 1'b0};
					bit_d   = bit_q + 3'd1;
					phase_d = PH_TX_LO;
				end
			end
			PH_TX_TAIL: if (over) phase_d = PH_ACK_REL;
			PH_ACK_REL: if (over) phase_d = PH_ACK_HI;
			PH_ACK_HI: if (over) begin
				poll_d  = 16'd0;
				phase_d = PH_ACK_POLL;
			end
			PH_ACK_POLL: begin
				// The slave's acknowledge is looked for on every tick here.
				if (!item.sda_in) begin
					phase_d = PH_ACK_LO;
					wait_d  = 16'd0;
				end else begin
					poll_d = poll_inc;
					if (poll_inc >= poll_lim || poll_inc == 16'd0) begin
						err_d   = 1'b1;
						phase_d = PH_ACK_LO;
						wait_d  = 16'd0;
					end
				end
			end
			PH_ACK_LO: if (over) begin
				if (stage_d != STAGE_ADDR) begin
					phase_d = PH_SP_A;
				end else if (!reading_d) begin
					stage_d = STAGE_FIRST;
					shift_d = cmd_d;
					bit_d   = 3'd0;
					phase_d = PH_TX_LO;
				end else if (err_d) begin
					phase_d = PH_SP_A;
				end else begin
					stage_d = STAGE_FIRST;
					bit_d   = 3'd0;
					shift_d = 8'd0;
					phase_d = PH_RX_HI;
				end
			end
			PH_RX_HI: if (over) begin
				shift_d = {shift_q[6:0], item.sda_in};
				phase_d = PH_RX_LO;
			end
			PH_RX_LO: if (over) begin
				if (bit_q == 3'd7) begin
					if (stage_d == STAGE_FIRST) begin
						first_d = shift_q;
						stage_d = STAGE_SECOND;
						phase_d = PH_MA_A;
					end else begin
						meas_d  = {first_q, shift_q};
						phase_d = PH_NA_A;
					end
				end else begin
					bit_d   = bit_q + 3'd1;
					phase_d = PH_RX_HI;
				end
			end
			PH_MA_A: if (over) phase_d = PH_MA_B;
			PH_MA_B: if (over) phase_d = PH_MA_C;
			PH_MA_C: if (over) begin
				bit_d   = 3'd0;
				shift_d = 8'd0;
				phase_d = PH_RX_HI;
			end
			PH_NA_A: if (over) phase_d = PH_NA_B;
			PH_NA_B: if (over) phase_d = PH_NA_C;
			PH_NA_C: if (over) phase_d = PH_SP_A;
			PH_SP_A: if (over) phase_d = PH_SP_B;
			PH_SP_B: if (over) begin
				done    = 1'b1;
				phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase

		result.scl_out   = scl;
		result.sda_out   = sda;
		result.busy_res  = (phase_e != PH_IDLE);
		result.done_res  = done;
		result.ack_error = err_d;
		result.raw_light = meas_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_q     <= '0;
			shift_q   <= '0;
			wait_q    <= '0;
			poll_q    <= '0;
			cmd_q     <= '0;
			reading_q <= 1'b0;
			first_q   <= '0;
			meas_q    <= '0;
			err_q     <= 1'b0;
			stage_q   <= STAGE_ADDR;
		end else if (step) begin
			phase_q   <= phase_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			wait_q    <= wait_d;
			poll_q    <= poll_d;
			cmd_q     <= cmd_d;
			reading_q <= reading_d;
			first_q   <= first_d;
			meas_q    <= meas_d;
			err_q     <= err_d;
			stage_q   <= stage_d;
		end
	end

endmodule

/* sv/i2clm_lux.sv */
// Lux scaler: raw reading times 20/3, truncated, by a reciprocal multiply.
`timescale 1ns / 1ps

module i2clm_lux (
	input  logic [i2clm_pkg::RawW-1:0] raw_light,
	output logic [i2clm_pkg::LuxW-1:0] lux_x16
);

	// ceil(2^23 / 3); exact for every dividend below 2^21.
	localparam logic [21:0] RECIP_3 = 22'd2796203;

	logic [20:0] times20;
	logic [42:0] product;

	assign times20 = {1'b0, raw_light, 4'b0} + {3'b0, raw_light, 2'b0};
	assign product = {22'd0, times20} * {21'd0, RECIP_3};
	assign lux_x16 = product[41:23];

endmodule

/* sv/i2c_light_sensor_master_core.sv */
// Top level of the light sensor I2C master: channels, configuration and registers.
// Order: a result appears in the cycle after its tick leaves the input register,
// which the tick does once the output register is free.
// Throughput: one tick accepted and one result given per clock cycle while the
// output side is ready; the sequencer steps its single state set once per tick.
// Reset: arst_n clears the sequencer to idle with both lines released, empties
// both stages and restores the configuration registers to their reset values.
`timescale 1ns / 1ps

module i2c_light_sensor_master_core (
	input  logic clk,
	input  logic arst_n,
	i2clm_req_if.sink   req,
	i2clm_res_if.source res,
	i2clm_cfg_if.sink   cfg
);

	i2clm_pkg::cfg_t  cfg_q;
	i2clm_pkg::item_t item_s1;
	i2clm_pkg::step_t step_res;
	i2clm_pkg::step_t res_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             exec;

	// The tick in the input register runs once the output register is free.
	assign exec      = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !valid_s1 || exec;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address    <= i2clm_pkg::RST_DEVICE_ADDRESS;
			cfg_q.half_period_ticks <= i2clm_pkg::RST_HALF_PERIOD_TICKS;
			cfg_q.ack_poll_limit    <= i2clm_pkg::RST_ACK_POLL_LIMIT;
		end else if (cfg.valid) begin
			case (cfg.index)
				i2clm_pkg::CFG_DEVICE_ADDRESS:
					cfg_q.device_address <= cfg.data[i2clm_pkg::AddrW-1:0];
				i2clm_pkg::CFG_HALF_PERIOD_TICKS: cfg_q.half_period_ticks <= cfg.data;
				i2clm_pkg::CFG_ACK_POLL_LIMIT:    cfg_q.ack_poll_limit <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.req_type <= req.req_type;
			item_s1.cmd_byte <= req.cmd_byte;
			item_s1.sda_in   <= req.sda_in;
		end
	end

	i2clm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (exec),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_q <= step_res;
		end
	end

	i2clm_lux u_lux (
		.raw_light (res_q.raw_light),
		.lux_x16   (res.lux_x16)
	);

	assign res.valid     = out_valid_q;
	assign res.scl_out   = res_q.scl_out;
	assign res.sda_out   = res_q.sda_out;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.ack_error = res_q.ack_error;
	assign res.raw_light = res_q.raw_light;

endmodule

/* sv/i2clm_checker.sv */
// Port-level checks of the light sensor I2C master, bound to the top level.
`timescale 1ns / 1ps

module i2clm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        scl_out,
	input logic        sda_out,
	input logic        busy_res,
	input logic        done_res,
	input logic        ack_error,
	input logic [15:0] raw_light,
	input logic [18:0] lux_x16
);

	logic [18:0] lux_lo, lux_hi;

	assign lux_lo = {3'b0, raw_light} * 19'd6;
	assign lux_hi = {3'b0, raw_light} * 19'd7;

	// A transaction can only finish on a tick that belongs to it.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> busy_res)
		else $error("done without busy");

	// Outside a transaction both lines are released.
	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !busy_res |-> scl_out && sda_out)
		else $error("line driven while idle");

	// The scaled value stays between raw*6 and raw*7, the bounds around raw*20/3.
	a_lux_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> lux_x16 >= lux_lo && lux_x16 <= lux_hi)
		else $error("lux out of range");

	// A result not taken holds until it is.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(raw_light) &&
		$stable(ack_error) && $stable(done_res))
		else $error("result changed while stalled");

endmodule

bind i2c_light_sensor_master_core i2clm_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.scl_out   (res.scl_out),
	.sda_out   (res.sda_out),
	.busy_res  (res.busy_res),
	.done_res  (res.done_res),
	.ack_error (res.ack_error),
	.raw_light (res.raw_light),
	.lux_x16   (res.lux_x16)
);
